### hdl/sslp_pkg.sv
// Shared types and constants for the substring search block.
// Used by the front stage, the command queue, the search engine and the top level.
`default_nettype none

package sslp_pkg;

    // Fixed widths of the pattern registers and of the byte lane
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 5;
    localparam int PAT_BYTES = 16;
    localparam int PAT_W     = PAT_BYTES * BYTE_W;
    localparam int CFG_W     = 64;
    localparam int ADDR_W    = 5;

    // Register indexes on the configuration port (byte address = 8 * index)
    localparam logic [1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [1:0] REG_PAT_LEN  = 2'd2;

    // One classified request passed from the front to the search engine
    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              holds_byte;
        logic              is_last;
    } t_cmd;

    // Search engine sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_CMP,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

### hdl/substring_search_length_pattern.sv
// Substring search top level: configuration registers, front stage, queue, search engine.
// Bytes append at one per cycle while the search engine is idle; each passes the front register and a queue entry.
// A closing request compares the buffer one byte at a time, each compare passing an issue
// state and a compare state, set by the single registered read port of the text store.
// Synchronous active-low reset clears the pattern registers (length one) and empties the buffer.
// Depends on sslp_pkg, sslp_front, sslp_queue and sslp_back.
`default_nettype none

module substring_search_length_pattern
    import sslp_pkg::*;
#(
    parameter int BUF_DEPTH = 256,
    parameter int PAT_MAX   = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [BYTE_W-1:0]             i_text_byte,
    input  wire logic                          i_holds_byte,
    input  wire logic                          i_is_last,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_found,
    output logic [$clog2(BUF_DEPTH+1)-1:0]     o_end_position,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ADDR_W-1:0]             paddr,
    input  wire logic [CFG_W-1:0]              pwdata,
    output logic [CFG_W-1:0]                   prdata,
    output logic                               pready
);

    logic [CFG_W-1:0] r_pat_low;
    logic [CFG_W-1:0] r_pat_high;
    logic [LEN_W-1:0] r_pat_len;
    logic             cfg_wr;
    logic [1:0]       reg_idx;

    logic q_full;
    logic q_push;
    logic q_empty;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd q_cmd;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:3];

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= LEN_W'(1);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_PAT_LOW:  r_pat_low  <= pwdata;
                REG_PAT_HIGH: r_pat_high <= pwdata;
                REG_PAT_LEN:  r_pat_len  <= pwdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        unique case (reg_idx)
            REG_PAT_LOW:  prdata = r_pat_low;
            REG_PAT_HIGH: prdata = r_pat_high;
            REG_PAT_LEN:  prdata = CFG_W'(r_pat_len);
            default:      prdata = '0;
        endcase
    end

    sslp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_text_byte  (i_text_byte),
        .i_holds_byte (i_holds_byte),
        .i_is_last    (i_is_last),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_cmd      (front_cmd)
    );

    sslp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    sslp_back #(
        .BUF_DEPTH (BUF_DEPTH),
        .PAT_MAX   (PAT_MAX)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_q_cmd          (q_cmd),
        .o_q_pop          (q_pop),
        .i_pattern        ({r_pat_high, r_pat_low}),
        .i_pattern_length (r_pat_len),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_found          (o_found),
        .o_end_position   (o_end_position)
    );

endmodule

`default_nettype wire

### hdl/sslp_front.sv
// Input stage: registers each request, drops idle requests and feeds the queue.
// Depends on sslp_pkg for the request type.
`default_nettype none

module sslp_front
    import sslp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [BYTE_W-1:0] i_text_byte,
    input  wire logic              i_holds_byte,
    input  wire logic              i_is_last,
    input  wire logic              i_q_full,
    output logic                   o_q_push,
    output t_cmd                   o_q_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    logic accept;

    // Hold the request while the queue is full
    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_q_push   = r_valid && !i_q_full;
    assign o_q_cmd    = r_cmd;

    // Keep only requests that append a byte or close the buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= i_holds_byte || i_is_last;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    // Capture the payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.text_byte  <= i_text_byte;
            r_cmd.holds_byte <= i_holds_byte;
            r_cmd.is_last    <= i_is_last;
        end
    end

endmodule

`default_nettype wire

### hdl/sslp_queue.sv
// Two-entry request queue between the front stage and the search engine.
// Depends on sslp_pkg for the request type.
`default_nettype none

module sslp_queue
    import sslp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_cmd
);

    t_cmd       r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_entry[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    // Store the pushed request
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

### hdl/sslp_back.sv
// Search engine: text store, fill count, byte-compare sequencer and result register.
// Depends on sslp_pkg for the request type, the state type and the widths.
`default_nettype none

module sslp_back
    import sslp_pkg::*;
#(
    parameter int BUF_DEPTH = 256,
    parameter int PAT_MAX   = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_q_empty,
    input  wire t_cmd                           i_q_cmd,
    output logic                                o_q_pop,
    input  wire logic [PAT_W-1:0]               i_pattern,
    input  wire logic [LEN_W-1:0]               i_pattern_length,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_found,
    output logic [$clog2(BUF_DEPTH+1)-1:0]      o_end_position
);

    localparam int POS_W = $clog2(BUF_DEPTH + 1);
    localparam int AW    = $clog2(BUF_DEPTH);

    logic [BYTE_W-1:0] r_store [BUF_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    t_state            r_state;
    t_state            n_state;
    logic [POS_W-1:0]  r_fill;
    logic [POS_W-1:0]  r_i;
    logic [LEN_W-1:0]  r_j;
    logic [LEN_W-1:0]  r_len;
    logic              r_res_found;
    logic [POS_W-1:0]  r_res_pos;
    logic              r_out_valid;
    logic              r_found;
    logic [POS_W-1:0]  r_end_pos;

    logic              wr_en;
    logic              start;
    logic              no_room;
    logic              byte_match;
    logic              last_j;
    logic              out_free;
    logic              load_out;
    logic [LEN_W-1:0]  eff_len;
    logic [POS_W:0]    span_end;
    logic [POS_W-1:0]  rd_pos;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] pat_byte;

    // Clamp the configured length into one to PAT_MAX
    always_comb begin
        priority if (i_pattern_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (i_pattern_length > LEN_W'(PAT_MAX)) begin
            eff_len = LEN_W'(PAT_MAX);
        end else begin
            eff_len = i_pattern_length;
        end
    end

    // Window and compare terms for the current start position
    assign span_end   = {1'b0, r_i} + (POS_W+1)'(r_len);
    assign no_room    = span_end > {1'b0, r_fill};
    assign rd_pos     = r_i + POS_W'(r_j);
    assign rd_addr    = rd_pos[AW-1:0];
    assign pat_byte   = i_pattern[{r_j[3:0], 3'b000} +: BYTE_W];
    assign byte_match = (r_rd_data == pat_byte);
    assign last_j     = (r_j + LEN_W'(1)) == r_len;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty && i_q_cmd.is_last) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                n_state = no_room ? ST_DONE : ST_CMP;
            end
            ST_CMP: begin
                n_state = (byte_match && last_j) ? ST_DONE : ST_ISSUE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_q_pop  = 1'b0;
        wr_en    = 1'b0;
        start    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_q_pop = !i_q_empty;
                wr_en   = !i_q_empty && i_q_cmd.holds_byte
                          && (r_fill < POS_W'(BUF_DEPTH));
                start   = !i_q_empty && i_q_cmd.is_last;
            end
            ST_DONE: begin
                load_out = out_free;
            end
            ST_ISSUE, ST_CMP: begin
            end
            default: begin
            end
        endcase
    end

    // Text store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_fill[AW-1:0]] <= i_q_cmd.text_byte;
        end
        r_rd_data <= r_store[rd_addr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_fill <= r_fill + POS_W'(1);
            end else if (load_out) begin
                r_fill <= '0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Search counters and result
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_i         <= '0;
            r_j         <= '0;
            r_len       <= eff_len;
            r_res_found <= 1'b0;
            r_res_pos   <= '0;
        end else if (r_state == ST_CMP) begin
            if (byte_match) begin
                if (last_j) begin
                    r_res_found <= 1'b1;
                    r_res_pos   <= span_end[POS_W-1:0];
                end else begin
                    r_j <= r_j + LEN_W'(1);
                end
            end else begin
                r_i <= r_i + POS_W'(1);
                r_j <= '0;
            end
        end
        if (load_out) begin
            r_found   <= r_res_found;
            r_end_pos <= r_res_pos;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_end_position = r_end_pos;

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the substring search block: directed table, then random buffers.
// Depends on sslp_pkg and substring_search_length_pattern; predicts each result not typed into its request.

module tb;
    import sslp_pkg::*;

    localparam int BUF_DEPTH     = 256;
    localparam int PAT_MAX       = 16;
    localparam int EP_W          = $clog2(BUF_DEPTH + 1);
    localparam int HALF_PERIOD   = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 150;
    localparam int PHASE_BUFFERS = 15;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic            found;
        logic [EP_W-1:0] end_position;
    } t_search_result;

    typedef enum logic {ROW_REQUEST, ROW_REGISTER} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [1:0]        sel;
        logic [CFG_W-1:0]  value;
        logic [BYTE_W-1:0] text;
        logic              holds;
        logic              last;
        logic              typed;
        t_search_result    res;
    } t_stim_row;

    typedef enum int {
        BUF_PLANT, BUF_TAIL, BUF_NARROW, BUF_NOISE, BUF_EMPTY, BUF_TINY, BUF_LONG
    } t_buffer_kind;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] in_text = '0;
    logic              in_holds = 1'b0;
    logic              in_last = 1'b0;
    logic              in_typed = 1'b0;
    t_search_result    in_typed_res = '0;

    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              out_found;
    logic [EP_W-1:0]   out_end_position;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [CFG_W-1:0]  pwdata = '0;
    logic [CFG_W-1:0]  prdata;
    logic              pready;

    // Own copy of the pattern registers and the text buffer
    logic [CFG_W-1:0]  pat_lo = '0;
    logic [CFG_W-1:0]  pat_hi = '0;
    logic [LEN_W-1:0]  pat_len = LEN_W'(1);
    logic [BYTE_W-1:0] held_text [BUF_DEPTH];
    int unsigned       held_count = 0;

    t_search_result    pending_results [$];
    t_stim_row         directed_rows [$];
    int unsigned       mismatches = 0;
    int unsigned       send_idle_pct = 17;
    int unsigned       recv_idle_pct = 86;
    int unsigned       phase_items = 0;
    int unsigned       phase_buffers = 0;
    logic              hold_req = 1'b0;
    logic              hold_seen = 1'b0;
    int unsigned       hold_left = 0;

    substring_search_length_pattern #(
        .BUF_DEPTH(BUF_DEPTH),
        .PAT_MAX  (PAT_MAX)
    ) DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_text_byte   (in_text),
        .i_holds_byte  (in_holds),
        .i_is_last     (in_last),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_found       (out_found),
        .o_end_position(out_end_position),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(HALF_PERIOD) clk = ~clk;

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Give up on a hung run
    initial begin
        #(20_000_000);
        $display("Some tests failed");
        $finish;
    end

    function automatic int unsigned pattern_span();
        if (pat_len == 0) return 1;
        if (pat_len > PAT_MAX) return PAT_MAX;
        return pat_len;
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_byte(input int unsigned k);
        logic [PAT_W-1:0] bits;
        bits = {pat_hi, pat_lo};
        return bits[BYTE_W*k +: BYTE_W];
    endfunction

    // Append the byte; on a closing request search the buffer, queue the result and empty it
    function automatic void load_or_search(input logic [BYTE_W-1:0] text, input logic holds,
                                           input logic last, input logic typed,
                                           input t_search_result typed_res);
        t_search_result res;
        int unsigned    span, start, k;
        bit             hit;
        if (holds && held_count < BUF_DEPTH) begin
            held_text[held_count] = text;
            held_count++;
        end
        if (!last) return;
        span = pattern_span();
        res = '0;
        for (start = 0; start + span <= held_count && !res.found; start++) begin
            hit = 1'b1;
            for (k = 0; k < span; k++)
                if (held_text[start + k] != pattern_byte(k)) hit = 1'b0;
            if (hit) begin
                res.found = 1'b1;
                res.end_position = EP_W'(start + span);
            end
        end
        held_count = 0;
        pending_results.push_back(typed ? typed_res : res);
    endfunction

    function automatic void flag_mismatch(input string what, input int unsigned want,
                                          input int unsigned got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch on %s: expected %0d, actual %0d", what, want, got);
    endfunction

    function automatic void add_request(input logic [BYTE_W-1:0] text, input logic holds,
                                        input logic last, input logic typed,
                                        input logic found, input int unsigned pos);
        t_stim_row row;
        row = '0;
        row.kind = ROW_REQUEST;
        row.text = text;
        row.holds = holds;
        row.last = last;
        row.typed = typed;
        row.res.found = found;
        row.res.end_position = EP_W'(pos);
        directed_rows.push_back(row);
    endfunction

    function automatic void add_register(input logic [1:0] sel, input logic [CFG_W-1:0] value);
        t_stim_row row;
        row = '0;
        row.kind = ROW_REGISTER;
        row.sel = sel;
        row.value = value;
        directed_rows.push_back(row);
    endfunction

    // Predict on every accepted request
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall)
            load_or_search(in_text, in_holds, in_last, in_typed, in_typed_res);
    end

    // Compare every accepted result with the oldest prediction
    always @(posedge clk) begin : result_check
        t_search_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result, end_position", 0, out_end_position);
            end else begin
                want = pending_results.pop_front();
                if (out_found !== want.found)
                    flag_mismatch("found", want.found, out_found);
                if (out_end_position !== want.end_position)
                    flag_mismatch("end_position", want.end_position, out_end_position);
            end
        end
    end

    // Drive the result stall: random idling, or one long hold when asked
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Offer one request after a random gap and hold it until accepted
    task automatic offer_request(input logic [BYTE_W-1:0] text, input logic holds,
                                 input logic last, input logic typed,
                                 input t_search_result typed_res);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_text <= text;
        in_holds <= holds;
        in_last <= last;
        in_typed <= typed;
        in_typed_res <= typed_res;
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid and wait until every predicted result has come out;
    // wait for a clock edge first so the last accepted request has been predicted
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] sel, input logic [CFG_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (sel)
            REG_PAT_LOW:  pat_lo = value;
            REG_PAT_HIGH: pat_hi = value;
            REG_PAT_LEN:  pat_len = value[LEN_W-1:0];
            default:      ;
        endcase
        @(posedge clk);
    endtask

    // Pick a new pattern, favouring short lengths and a narrow alphabet
    task automatic reconfigure();
        logic [CFG_W-1:0]  word [2];
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] alphabet [3];
        int unsigned       w, b;
        alphabet[0] = 8'h00;
        alphabet[1] = 8'hFF;
        alphabet[2] = 8'h61;
        wait_drained();
        case ($urandom_range(0, 9))
            0:       len = LEN_W'(1);
            1:       len = LEN_W'(PAT_MAX);
            2:       len = '0;
            3:       len = LEN_W'($urandom_range(PAT_MAX + 1, 31));
            default: len = LEN_W'($urandom_range(2, 8));
        endcase
        for (w = 0; w < 2; w++) begin
            if ($urandom_range(0, 1)) begin
                word[w] = {$urandom, $urandom};
            end else begin
                for (b = 0; b < 8; b++)
                    word[w][BYTE_W*b +: BYTE_W] = alphabet[$urandom_range(0, 2)];
            end
        end
        write_register(REG_PAT_LOW, word[0]);
        write_register(REG_PAT_HIGH, word[1]);
        write_register(REG_PAT_LEN, CFG_W'(len));
    endtask

    // Build one buffer of the given shape and send it, closing it with the last byte or alone
    task automatic send_buffer(input t_buffer_kind kind);
        logic [BYTE_W-1:0] text_q [$];
        int unsigned       span, n, at, cut, k, j;
        bit                plant, close_on_byte;
        span = pattern_span();
        plant = (kind == BUF_PLANT || kind == BUF_LONG);
        case (kind)
            BUF_LONG:  n = $urandom_range(248, 270);
            BUF_EMPTY: n = 0;
            BUF_TINY:  n = $urandom_range(0, 1);
            default:   n = $urandom_range(0, 14);
        endcase
        // a long buffer may end its match exactly at the last store entry
        if (kind == BUF_LONG && $urandom_range(0, 1))
            at = BUF_DEPTH - span;
        else
            at = $urandom_range(0, n);
        for (k = 0; k <= n; k++) begin
            if (plant && k == at)
                for (j = 0; j < span; j++) text_q.push_back(pattern_byte(j));
            if (k < n) begin
                if (kind == BUF_NARROW)
                    text_q.push_back(pattern_byte($urandom_range(0, span - 1)));
                else
                    text_q.push_back(BYTE_W'($urandom));
            end
        end
        // cut the pattern short at the end of the buffer
        if (kind == BUF_TAIL) begin
            cut = $urandom_range(0, span - 1);
            for (j = 0; j < cut; j++) text_q.push_back(pattern_byte(j));
        end
        close_on_byte = (text_q.size() != 0) && $urandom_range(0, 1);
        for (k = 0; k < text_q.size(); k++) begin
            if ($urandom_range(0, 99) < 4)
                offer_request(BYTE_W'($urandom), 1'b0, 1'b0, 1'b0, '0);
            offer_request(text_q[k], 1'b1, close_on_byte && k == text_q.size() - 1, 1'b0, '0);
            phase_items++;
        end
        if (!close_on_byte) begin
            offer_request(BYTE_W'($urandom), 1'b0, 1'b1, 1'b0, '0);
            phase_items++;
        end
        phase_buffers++;
    endtask

    initial begin : stimulus
        t_stim_row    row;
        t_buffer_kind kind;
        int unsigned  r, phase, pick;

        // Reset pattern is one zero byte
        add_request(8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 0);
        add_request(8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 1);
        add_request(8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 0);
        add_request(8'h5A, 1'b0, 1'b0, 1'b0, 1'b0, 0);
        add_request(8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 0);
        add_request(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 2);
        // Pattern "ABCDEFGHIJKLMNOP"; a zero length acts as one
        add_register(REG_PAT_LOW, 64'h4847_4645_4443_4241);
        add_register(REG_PAT_HIGH, 64'h504F_4E4D_4C4B_4A49);
        add_register(REG_PAT_LEN, '0);
        add_request(8'h42, 1'b1, 1'b0, 1'b0, 1'b0, 0);
        add_request(8'h41, 1'b1, 1'b1, 1'b1, 1'b1, 2);
        // Oversized length clamps to sixteen, longer than the buffer
        add_register(REG_PAT_LEN, 64'd31);
        add_request(8'h41, 1'b1, 1'b0, 1'b0, 1'b0, 0);
        add_request(8'h42, 1'b1, 1'b0, 1'b0, 1'b0, 0);
        add_request(8'h43, 1'b1, 1'b1, 1'b1, 1'b0, 0);
        // Two-byte pattern: a match after a false start, then one cut off at the end
        add_register(REG_PAT_LEN, 64'd2);
        add_request(8'h43, 1'b1, 1'b0, 1'b0, 1'b0, 0);
        add_request(8'h41, 1'b1, 1'b0, 1'b0, 1'b0, 0);
        add_request(8'h41, 1'b1, 1'b0, 1'b0, 1'b0, 0);
        add_request(8'h42, 1'b1, 1'b1, 1'b0, 1'b0, 0);
        add_request(8'h58, 1'b1, 1'b0, 1'b0, 1'b0, 0);
        add_request(8'h41, 1'b1, 1'b1, 1'b1, 1'b0, 0);

        wait (rst_n);
        @(posedge clk);

        // Walk the directed table
        for (r = 0; r < directed_rows.size(); r++) begin
            row = directed_rows[r];
            if (row.kind == ROW_REGISTER) begin
                wait_drained();
                write_register(row.sel, row.value);
            end else begin
                offer_request(row.text, row.holds, row.last, row.typed, row.res);
            end
        end

        // Random buffers in three idling phases
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 86 : 0;
            recv_idle_pct <= (phase == 0) ? 86 : (phase == 1) ? 17 : 0;
            phase_items = 0;
            phase_buffers = 0;
            while (phase_items < PHASE_ITEMS || phase_buffers < PHASE_BUFFERS) begin
                if (phase_buffers % 6 == 0) reconfigure();
                // hold results back while tiny buffers pile up behind them
                if (phase == 0 && phase_buffers == 3) begin
                    hold_req <= ~hold_req;
                    repeat (20) send_buffer(BUF_TINY);
                end
                pick = $urandom_range(0, 19);
                if (pick < 8)       kind = BUF_PLANT;
                else if (pick < 11) kind = BUF_TAIL;
                else if (pick < 14) kind = BUF_NARROW;
                else if (pick < 17) kind = BUF_NOISE;
                else if (pick < 18) kind = BUF_EMPTY;
                else                kind = BUF_TINY;
                if (phase == 2 && phase_buffers == 4) kind = BUF_LONG;
                send_buffer(kind);
            end
        end

        wait_drained();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
